// File: src/jpca_pkg.sv
// ----------------------------------------------------------------------------
// jpca_pkg: shared types and constants for the joint penalty cost accumulator
// Holds the configuration register map, the item, result and control structs,
// and the dead band helper used by the core.
// ----------------------------------------------------------------------------
package jpca_pkg;

	// Sizes of the fixed fields.
	localparam int unsigned MAX_JOINTS_DEF = 16;
	localparam int unsigned JIDX_W         = 4;
	localparam int unsigned COST_W         = 48;
	localparam int unsigned CFG_IDX_W      = 3;
	localparam int unsigned CFG_DATA_W     = 32;
	localparam int unsigned XBAND_W        = 19;

	localparam logic [COST_W-1:0] COST_MAX     = {COST_W{1'b1}};
	localparam logic [15:0]       INV_DT_RESET = 16'd1600;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_W_DISP   = 3'd0,
		REG_W_LIMIT  = 3'd1,
		REG_W_WINDOW = 3'd2,
		REG_W_VEL    = 3'd3,
		REG_W_ACC    = 3'd4,
		REG_INV_DT   = 3'd5,
		REG_WINDOW   = 3'd6,
		REG_SELECT   = 3'd7
	} cfg_reg_t;

	// Configuration register contents.
	typedef struct packed {
		logic [15:0] weight_displacement;
		logic [15:0] weight_joint_limits;
		logic [15:0] weight_window;
		logic [15:0] weight_velocity;
		logic [15:0] weight_acceleration;
		logic [15:0] inverse_time_step;
		logic [31:0] window_bounds;
		logic [7:0]  joint_select;
	} cfg_t;

	// One joint as delivered by the input channel.
	typedef struct packed {
		logic signed [15:0] position;
		logic signed [15:0] initial_guess;
		logic signed [15:0] limit_low;
		logic signed [15:0] limit_high;
		logic               unbounded;
		logic [15:0]        velocity_limit;
		logic [23:0]        acceleration_limit;
		logic               last_joint;
	} item_t;

	// One evaluation result.
	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              saturated;
	} result_t;

	// Control from the top level into the core.
	typedef struct packed {
		logic start;
		logic out_free;
	} core_ctrl_t;

	// Status from the core back to the top level.
	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

	// Dead band distance in Q.14: max(0, 2*|2p - lo - hi| - (hi - lo)).
	function automatic logic [XBAND_W-1:0] dead_band(
		input logic signed [15:0] p,
		input logic signed [15:0] lo,
		input logic signed [15:0] hi
	);
		logic signed [20:0] centre;
		logic signed [20:0] span;
		logic signed [20:0] gap;
		centre = (21'(p) <<< 1) - 21'(lo) - 21'(hi);
		if (centre < 0) begin
			centre = -centre;
		end
		span = 21'(hi) - 21'(lo);
		gap = (centre <<< 1) - span;
		if (gap <= 0) begin
			dead_band = '0;
		end else begin
			dead_band = gap[XBAND_W-1:0];
		end
	endfunction

endpackage

// File: src/jpca_if.sv
// ----------------------------------------------------------------------------
// jpca_if: valid/ready channels of the joint penalty cost accumulator
// jpca_item_if carries one joint per transaction, jpca_result_if carries one
// evaluation result per transaction.
// ----------------------------------------------------------------------------
interface jpca_item_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] position;
	logic signed [15:0] initial_guess;
	logic signed [15:0] limit_low;
	logic signed [15:0] limit_high;
	logic               unbounded;
	logic [15:0]        velocity_limit;
	logic [23:0]        acceleration_limit;
	logic               last_joint;

	modport source (
		output valid, position, initial_guess, limit_low, limit_high, unbounded,
		       velocity_limit, acceleration_limit, last_joint,
		input  ready
	);

	modport sink (
		input  valid, position, initial_guess, limit_low, limit_high, unbounded,
		       velocity_limit, acceleration_limit, last_joint,
		output ready
	);
endinterface

interface jpca_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] cost;
	logic        saturated;

	modport source (
		output valid, cost, saturated,
		input  ready
	);

	modport sink (
		input  valid, cost, saturated,
		output ready
	);
endinterface

// File: src/jpca_core.sv
// ----------------------------------------------------------------------------
// jpca_core: sequenced penalty evaluation around one shared 32x32 multiplier
// Each term runs load, weight (two products), square (three products), scale
// and accumulate steps; velocity and acceleration first form their rates.
// ----------------------------------------------------------------------------
module jpca_core #(
	parameter int unsigned MAX_JOINTS = jpca_pkg::MAX_JOINTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  jpca_pkg::cfg_t       cfg,
	input  jpca_pkg::item_t      item,
	input  jpca_pkg::core_ctrl_t ctrl,
	output jpca_pkg::core_stat_t stat,
	output jpca_pkg::result_t    res
);

	localparam int unsigned JW = jpca_pkg::JIDX_W;
	localparam int unsigned CW = jpca_pkg::COST_W;
	localparam logic [JW-1:0] JOINT_WRAP = JW'(MAX_JOINTS - 1);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP_VEL,
		ST_PREP_SQ,
		ST_PREP_ACC,
		ST_LOAD,
		ST_V_LO,
		ST_V_HI,
		ST_SQ_LL,
		ST_SQ_LH,
		ST_SQ_HH,
		ST_SCALE,
		ST_ACCUM,
		ST_FINISH
	} state_t;

	typedef enum logic [2:0] {
		T_DISP,
		T_LIMIT,
		T_WINDOW,
		T_VEL,
		T_ACC
	} term_t;

	state_t          state_q;
	term_t           term_q;
	logic [CW-1:0]   cost_q;
	logic            ovf_q;
	logic [JW-1:0]   joint_q;

	jpca_pkg::item_t item_q;
	logic [31:0]     its2_q;
	logic [CW-1:0]   rate_q;
	logic [CW-1:0]   e_q;
	logic [63:0]     v_q;
	logic [127:0]    acc_q;
	logic [CW-1:0]   pen_q;

	logic signed [16:0]             diff;
	logic [15:0]                    disp_abs;
	logic [jpca_pkg::XBAND_W-1:0]   x_limit;
	logic [jpca_pkg::XBAND_W-1:0]   x_window;
	logic                           win_hit;
	logic                           vel_hit;
	logic [CW-1:0]                  lim_sel;
	logic [CW-1:0]                  excess;
	logic [CW-1:0]                  e_next;
	logic [15:0]                    w_sel;
	logic [6:0]                     shamt;
	logic [127:0]                   scaled;
	logic                           pen_clip;
	logic [CW:0]                    sum;
	logic [31:0]                    mul_a;
	logic [31:0]                    mul_b;
	logic [63:0]                    prod;

	// Joint quantities derived from the held item.
	assign diff     = 17'(item_q.position) - 17'(item_q.initial_guess);
	assign disp_abs = diff[16] ? 16'(-diff) : diff[15:0];
	assign x_limit  = jpca_pkg::dead_band(item_q.position, item_q.limit_low,
		item_q.limit_high);
	assign x_window = jpca_pkg::dead_band(item_q.position,
		$signed(cfg.window_bounds[15:0]), $signed(cfg.window_bounds[31:16]));
	assign win_hit  = (joint_q == cfg.joint_select[3:0]);
	assign vel_hit  = (joint_q == cfg.joint_select[7:4]);

	// Shared rate-over-limit compare and subtract.
	assign lim_sel = (term_q == T_VEL) ? {23'd0, item_q.velocity_limit, 9'd0}
		: {11'd0, item_q.acceleration_limit, 13'd0};
	assign excess  = (rate_q > lim_sel) ? (rate_q - lim_sel) : '0;

	// Penalty base, weight and output scaling for the current term.
	always_comb begin
		e_next = '0;
		w_sel  = '0;
		shamt  = 7'd0;
		unique case (term_q)
			T_DISP: begin
				e_next = {32'd0, disp_abs};
				w_sel  = cfg.weight_displacement;
				shamt  = 7'd26;
			end
			T_LIMIT: begin
				e_next = item_q.unbounded ? '0 : {29'd0, x_limit};
				w_sel  = cfg.weight_joint_limits;
				shamt  = 7'd28;
			end
			T_WINDOW: begin
				e_next = win_hit ? {29'd0, x_window} : '0;
				w_sel  = cfg.weight_window;
				shamt  = 7'd28;
			end
			T_VEL: begin
				e_next = vel_hit ? excess : '0;
				w_sel  = cfg.weight_velocity;
				shamt  = 7'd34;
			end
			T_ACC: begin
				e_next = excess;
				w_sel  = cfg.weight_acceleration;
				shamt  = 7'd42;
			end
			default: begin
				e_next = '0;
				w_sel  = '0;
				shamt  = 7'd0;
			end
		endcase
	end

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_PREP_VEL: begin
				mul_a = {16'd0, disp_abs};
				mul_b = {16'd0, cfg.inverse_time_step};
			end
			ST_PREP_SQ: begin
				mul_a = {16'd0, cfg.inverse_time_step};
				mul_b = {16'd0, cfg.inverse_time_step};
			end
			ST_PREP_ACC: begin
				mul_a = {16'd0, disp_abs};
				mul_b = its2_q;
			end
			ST_V_LO: begin
				mul_a = e_q[31:0];
				mul_b = {16'd0, w_sel};
			end
			ST_V_HI: begin
				mul_a = {16'd0, e_q[47:32]};
				mul_b = {16'd0, w_sel};
			end
			ST_SQ_LL: begin
				mul_a = v_q[31:0];
				mul_b = v_q[31:0];
			end
			ST_SQ_LH: begin
				mul_a = v_q[31:0];
				mul_b = v_q[63:32];
			end
			ST_SQ_HH: begin
				mul_a = v_q[63:32];
				mul_b = v_q[63:32];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = mul_a * mul_b;

	// Scaling of the exact square and saturating accumulation.
	assign scaled   = acc_q >> shamt;
	assign pen_clip = |scaled[127:CW];
	assign sum      = {1'b0, cost_q} + {1'b0, pen_q};

	// Sequencer, running cost, overflow flag and joint counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			term_q  <= T_DISP;
			cost_q  <= '0;
			ovf_q   <= 1'b0;
			joint_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (ctrl.start) begin
						term_q  <= T_DISP;
						state_q <= ST_LOAD;
					end
				end
				ST_PREP_VEL: state_q <= ST_LOAD;
				ST_PREP_SQ:  state_q <= ST_PREP_ACC;
				ST_PREP_ACC: state_q <= ST_LOAD;
				ST_LOAD:     state_q <= ST_V_LO;
				ST_V_LO:     state_q <= ST_V_HI;
				ST_V_HI:     state_q <= ST_SQ_LL;
				ST_SQ_LL:    state_q <= ST_SQ_LH;
				ST_SQ_LH:    state_q <= ST_SQ_HH;
				ST_SQ_HH:    state_q <= ST_SCALE;
				ST_SCALE: begin
					if (pen_clip) begin
						ovf_q <= 1'b1;
					end
					state_q <= ST_ACCUM;
				end
				ST_ACCUM: begin
					if (sum[CW]) begin
						cost_q <= jpca_pkg::COST_MAX;
						ovf_q  <= 1'b1;
					end else begin
						cost_q <= sum[CW-1:0];
					end
					unique case (term_q)
						T_DISP: begin
							term_q  <= T_LIMIT;
							state_q <= ST_LOAD;
						end
						T_LIMIT: begin
							term_q  <= T_WINDOW;
							state_q <= ST_LOAD;
						end
						T_WINDOW: begin
							term_q  <= T_VEL;
							state_q <= ST_PREP_VEL;
						end
						T_VEL: begin
							term_q  <= T_ACC;
							state_q <= ST_PREP_SQ;
						end
						default: begin
							state_q <= ST_FINISH;
						end
					endcase
				end
				ST_FINISH: begin
					if (!item_q.last_joint) begin
						joint_q <= (joint_q == JOINT_WRAP) ? '0 : joint_q + 1'b1;
						state_q <= ST_IDLE;
					end else if (ctrl.out_free) begin
						cost_q  <= '0;
						ovf_q   <= 1'b0;
						joint_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers, loaded step by step.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (ctrl.start) begin
					item_q <= item;
				end
			end
			ST_PREP_VEL: rate_q <= prod[CW-1:0];
			ST_PREP_SQ:  its2_q <= prod[31:0];
			ST_PREP_ACC: rate_q <= prod[CW-1:0];
			ST_LOAD:     e_q    <= e_next;
			ST_V_LO:     v_q    <= prod;
			ST_V_HI:     v_q    <= v_q + {prod[31:0], 32'd0};
			ST_SQ_LL:    acc_q  <= {64'd0, prod};
			ST_SQ_LH:    acc_q  <= acc_q + ({64'd0, prod} << 33);
			ST_SQ_HH:    acc_q  <= acc_q + {prod, 64'd0};
			ST_SCALE:    pen_q  <= pen_clip ? jpca_pkg::COST_MAX : scaled[CW-1:0];
			default: begin
			end
		endcase
	end

	assign stat.busy     = (state_q != ST_IDLE);
	assign stat.done     = (state_q == ST_FINISH) && item_q.last_joint && ctrl.out_free;
	assign res.cost      = cost_q;
	assign res.saturated = ovf_q;

endmodule

// File: src/joint_penalty_cost_accumulator.sv
// ----------------------------------------------------------------------------
// joint_penalty_cost_accumulator: weighted joint penalty cost over a joint stream
// The core takes one joint at a time and accepts the next only once it is idle
// again; each joint runs five terms of eight steps each plus three rate products,
// all through one shared 32x32 multiplier. The result is offered from the output
// register when the last joint finishes; the core waits only if it is still full.
// Reset clears the cost, counter and flag and sets the registers to defaults.
// ----------------------------------------------------------------------------
module joint_penalty_cost_accumulator #(
	parameter int unsigned MAX_JOINTS = jpca_pkg::MAX_JOINTS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [jpca_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [jpca_pkg::CFG_DATA_W-1:0]   cfg_data,
	jpca_item_if.sink                         item,
	jpca_result_if.source                     result
);

	jpca_pkg::cfg_t       cfg_q;
	jpca_pkg::item_t      item_in;
	jpca_pkg::core_ctrl_t ctrl;
	jpca_pkg::core_stat_t stat;
	jpca_pkg::result_t    res;
	jpca_pkg::result_t    out_q;
	logic                 out_valid_q;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight_displacement <= '0;
			cfg_q.weight_joint_limits <= '0;
			cfg_q.weight_window       <= '0;
			cfg_q.weight_velocity     <= '0;
			cfg_q.weight_acceleration <= '0;
			cfg_q.inverse_time_step   <= jpca_pkg::INV_DT_RESET;
			cfg_q.window_bounds       <= '0;
			cfg_q.joint_select        <= '0;
		end else if (cfg_wr_en) begin
			unique case (jpca_pkg::cfg_reg_t'(cfg_index))
				jpca_pkg::REG_W_DISP:   cfg_q.weight_displacement <= cfg_data[15:0];
				jpca_pkg::REG_W_LIMIT:  cfg_q.weight_joint_limits <= cfg_data[15:0];
				jpca_pkg::REG_W_WINDOW: cfg_q.weight_window       <= cfg_data[15:0];
				jpca_pkg::REG_W_VEL:    cfg_q.weight_velocity     <= cfg_data[15:0];
				jpca_pkg::REG_W_ACC:    cfg_q.weight_acceleration <= cfg_data[15:0];
				jpca_pkg::REG_INV_DT:   cfg_q.inverse_time_step   <= cfg_data[15:0];
				jpca_pkg::REG_WINDOW:   cfg_q.window_bounds       <= cfg_data[31:0];
				jpca_pkg::REG_SELECT:   cfg_q.joint_select        <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	// Input transaction into the core.
	assign item_in.position           = item.position;
	assign item_in.initial_guess      = item.initial_guess;
	assign item_in.limit_low          = item.limit_low;
	assign item_in.limit_high         = item.limit_high;
	assign item_in.unbounded          = item.unbounded;
	assign item_in.velocity_limit     = item.velocity_limit;
	assign item_in.acceleration_limit = item.acceleration_limit;
	assign item_in.last_joint         = item.last_joint;

	assign item.ready    = !stat.busy;
	assign ctrl.start    = item.valid && !stat.busy;
	assign ctrl.out_free = !out_valid_q || result.ready;

	jpca_core #(
		.MAX_JOINTS (MAX_JOINTS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.item   (item_in),
		.ctrl   (ctrl),
		.stat   (stat),
		.res    (res)
	);

	// Output register: holds a result until its transaction completes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (stat.done) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			out_q <= res;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.cost      = out_q.cost;
	assign result.saturated = out_q.saturated;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the joint penalty cost accumulator
// Streams joints through the valid/ready item channel under several register
// settings, predicts each evaluation cost from a behavioural model of the
// penalty terms, and compares every result transaction field by field.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import jpca_pkg::*;

	// Run shape.
	localparam int RANDOM_ITEMS   = 400;
	localparam int SETTLE_CYCLES  = 64;
	localparam int HOLD_CYCLES    = 600;
	// The slowest legal gap between transactions is the receiver hold-off plus
	// one joint through the core and a sender burst; the limit allows several times that.
	localparam int WATCHDOG_LIMIT = 4000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	jpca_item_if   item_ch ();
	jpca_result_if result_ch ();

	joint_penalty_cost_accumulator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item_ch),
		.result    (result_ch)
	);

	// Clock generation.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Bench state shared between the processes.
	item_t   joint_queue[$];
	result_t cost_due[$];
	item_t   sent_joint;
	cfg_t    reg_mirror;
	int      queued_total   = 0;
	int      accepted_total = 0;
	int      mismatches     = 0;
	bit      calm           = 1'b0;
	bit      hold_request   = 1'b0;
	bit      hold_taken     = 1'b0;
	int      hold_left      = 0;
	int      send_gap       = 0;
	int      take_gap       = 0;
	int      stall_cycles   = 0;

	// Predicted running state of the evaluation in progress.
	logic [COST_W-1:0] run_cost;
	logic [JIDX_W-1:0] run_index;
	logic              run_clamped;

	task automatic report_mismatch(input string what);
		$display("MISMATCH at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	// Squares a penalty, scales it down, and adds it to the running cost with
	// clamping of both the term and the sum.
	task automatic add_squared(input logic [63:0] v, input int unsigned sh);
		logic [127:0]      sq;
		logic [COST_W-1:0] term;
		logic [COST_W:0]   sum;
		sq = ({64'd0, v} * {64'd0, v}) >> sh;
		if (sq > 128'(COST_MAX)) begin
			term = COST_MAX;
			run_clamped = 1'b1;
		end else begin
			term = sq[COST_W-1:0];
		end
		sum = {1'b0, run_cost} + {1'b0, term};
		if (sum > {1'b0, COST_MAX}) begin
			run_cost = COST_MAX;
			run_clamped = 1'b1;
		end else begin
			run_cost = sum[COST_W-1:0];
		end
	endtask

	// Dead band excess max(0, 2*|2p - lo - hi| - (hi - lo)) for the band [lo, hi], in Q.14.
	function automatic logic [63:0] band_excess(input logic signed [15:0] p,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		longint c;
		longint x;
		c = 2 * longint'(p) - longint'(lo) - longint'(hi);
		if (c < 0) begin
			c = -c;
		end
		x = 2 * c - (longint'(hi) - longint'(lo));
		return (x > 0) ? 64'(x) : 64'd0;
	endfunction

	// Adds the penalties of one accepted joint and, on the last joint of an
	// evaluation, records the cost that the block must deliver.
	task automatic accumulate_joint(input item_t j);
		longint      d;
		logic [63:0] a;
		logic [63:0] its;
		logic [63:0] rate;
		logic [63:0] lim;
		d = longint'(j.position) - longint'(j.initial_guess);
		a = (d < 0) ? 64'(-d) : 64'(d);
		its = 64'(reg_mirror.inverse_time_step);
		if (reg_mirror.weight_displacement != 0) begin
			add_squared(a * reg_mirror.weight_displacement, 26);
		end
		if (!j.unbounded) begin
			add_squared(band_excess(j.position, j.limit_low, j.limit_high) *
				reg_mirror.weight_joint_limits, 28);
		end
		if (reg_mirror.joint_select[3:0] == run_index) begin
			add_squared(band_excess(j.position, reg_mirror.window_bounds[15:0],
				reg_mirror.window_bounds[31:16]) * reg_mirror.weight_window, 28);
		end
		if (reg_mirror.joint_select[7:4] == run_index && reg_mirror.weight_velocity != 0) begin
			rate = a * its;
			lim = 64'(j.velocity_limit) << 9;
			if (rate > lim) begin
				add_squared((rate - lim) * reg_mirror.weight_velocity, 34);
			end
		end
		if (reg_mirror.weight_acceleration != 0) begin
			rate = a * (its * its);
			lim = 64'(j.acceleration_limit) << 13;
			if (rate > lim) begin
				add_squared((rate - lim) * reg_mirror.weight_acceleration, 42);
			end
		end
		run_index = (run_index == JIDX_W'(MAX_JOINTS_DEF - 1)) ? '0 : run_index + 1'b1;
		if (j.last_joint) begin
			cost_due.push_back('{cost: run_cost, saturated: run_clamped});
			run_cost = '0;
			run_index = '0;
			run_clamped = 1'b0;
		end
	endtask

	// Input driver: presents queued joints, with random idle bursts.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_ch.valid              <= 1'b0;
			item_ch.position           <= '0;
			item_ch.initial_guess      <= '0;
			item_ch.limit_low          <= '0;
			item_ch.limit_high         <= '0;
			item_ch.unbounded          <= 1'b0;
			item_ch.velocity_limit     <= '0;
			item_ch.acceleration_limit <= '0;
			item_ch.last_joint         <= 1'b0;
		end else begin
			if (item_ch.valid && item_ch.ready) begin
				accumulate_joint(sent_joint);
				accepted_total++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (send_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(1, 19);
				end
				if (send_gap > 0) begin
					send_gap--;
					item_ch.valid <= 1'b0;
				end else if (joint_queue.size() != 0) begin
					sent_joint = joint_queue.pop_front();
					item_ch.valid              <= 1'b1;
					item_ch.position           <= sent_joint.position;
					item_ch.initial_guess      <= sent_joint.initial_guess;
					item_ch.limit_low          <= sent_joint.limit_low;
					item_ch.limit_high         <= sent_joint.limit_high;
					item_ch.unbounded          <= sent_joint.unbounded;
					item_ch.velocity_limit     <= sent_joint.velocity_limit;
					item_ch.acceleration_limit <= sent_joint.acceleration_limit;
					item_ch.last_joint         <= sent_joint.last_joint;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: checks each result transaction and drives ready with
	// random stalls and, once, a long hold-off.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (cost_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result cost=%0d sat=%0b",
						result_ch.cost, result_ch.saturated));
				end else begin
					if (result_ch.cost !== cost_due[0].cost) begin
						report_mismatch($sformatf("cost %0d, predicted %0d",
							result_ch.cost, cost_due[0].cost));
					end
					if (result_ch.saturated !== cost_due[0].saturated) begin
						report_mismatch($sformatf("saturated %0b, predicted %0b",
							result_ch.saturated, cost_due[0].saturated));
					end
					void'(cost_due.pop_front());
				end
			end
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ch.ready <= 1'b0;
			end else begin
				if (take_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
					take_gap = $urandom_range(1, 19);
				end
				if (take_gap > 0) begin
					take_gap--;
					result_ch.ready <= 1'b0;
				end else begin
					result_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			stall_cycles = 0;
		end else begin
			stall_cycles++;
		end
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Writes one register and mirrors it for the predictor.
	task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			REG_W_DISP:   reg_mirror.weight_displacement = value[15:0];
			REG_W_LIMIT:  reg_mirror.weight_joint_limits = value[15:0];
			REG_W_WINDOW: reg_mirror.weight_window = value[15:0];
			REG_W_VEL:    reg_mirror.weight_velocity = value[15:0];
			REG_W_ACC:    reg_mirror.weight_acceleration = value[15:0];
			REG_INV_DT:   reg_mirror.inverse_time_step = value[15:0];
			REG_WINDOW:   reg_mirror.window_bounds = value;
			REG_SELECT:   reg_mirror.joint_select = value[7:0];
			default:      ;
		endcase
	endtask

	// Writes every register; unused upper data bits carry random junk.
	task automatic load_config(input cfg_t c);
		write_reg(REG_W_DISP,   {16'($urandom()), c.weight_displacement});
		write_reg(REG_W_LIMIT,  {16'($urandom()), c.weight_joint_limits});
		write_reg(REG_W_WINDOW, {16'($urandom()), c.weight_window});
		write_reg(REG_W_VEL,    {16'($urandom()), c.weight_velocity});
		write_reg(REG_W_ACC,    {16'($urandom()), c.weight_acceleration});
		write_reg(REG_INV_DT,   {16'($urandom()), c.inverse_time_step});
		write_reg(REG_WINDOW,   c.window_bounds);
		write_reg(REG_SELECT,   {24'($urandom()), c.joint_select});
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic queue_joint(input item_t j);
		joint_queue.push_back(j);
		queued_total++;
	endtask

	// Waits until every joint is taken and every cost has come back, then
	// lets the core finish any joint that produces no result.
	task automatic drain();
		while (accepted_total != queued_total || cost_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic cfg_t config_of(input int wd, input int wl, input int ww,
			input int wv, input int wa, input int its, input logic [31:0] win,
			input int sel);
		cfg_t c;
		c.weight_displacement = 16'(wd);
		c.weight_joint_limits = 16'(wl);
		c.weight_window       = 16'(ww);
		c.weight_velocity     = 16'(wv);
		c.weight_acceleration = 16'(wa);
		c.inverse_time_step   = 16'(its);
		c.window_bounds       = win;
		c.joint_select        = 8'(sel);
		return c;
	endfunction

	function automatic item_t make_joint(input int pos, input int guess, input int lo,
			input int hi, input bit unb, input int vlim, input int alim, input bit last);
		item_t j;
		j.position           = 16'(pos);
		j.initial_guess      = 16'(guess);
		j.limit_low          = 16'(lo);
		j.limit_high         = 16'(hi);
		j.unbounded          = unb;
		j.velocity_limit     = 16'(vlim);
		j.acceleration_limit = 24'(alim);
		j.last_joint         = last;
		return j;
	endfunction

	// Angles biased towards the extremes, zero and the region around zero.
	function automatic logic [15:0] pick_angle();
		case ($urandom_range(0, 9))
			0:       return 16'h8000;
			1:       return 16'h7FFF;
			2:       return 16'h0000;
			3, 4, 5: return 16'($urandom_range(0, 4000) - 2000);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_weight();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return 16'($urandom());
			default: return 16'($urandom_range(1, 300));
		endcase
	endfunction

	function automatic cfg_t random_config();
		cfg_t        c;
		logic [15:0] lo;
		c.weight_displacement = pick_weight();
		c.weight_joint_limits = pick_weight();
		c.weight_window       = pick_weight();
		c.weight_velocity     = pick_weight();
		c.weight_acceleration = pick_weight();
		case ($urandom_range(0, 5))
			0:       c.inverse_time_step = 16'd1;
			1:       c.inverse_time_step = 16'hFFFF;
			2:       c.inverse_time_step = 16'($urandom_range(1, 65535));
			default: c.inverse_time_step = 16'($urandom_range(400, 2400));
		endcase
		lo = pick_angle();
		case ($urandom_range(0, 3))
			0:       c.window_bounds = $urandom();
			// Upper bound below the lower one.
			1:       c.window_bounds = {lo, 16'(lo + 16'($urandom_range(0, 8192)))};
			default: c.window_bounds = {16'(lo + 16'($urandom_range(0, 16384))), lo};
		endcase
		c.joint_select = 8'($urandom_range(0, 255));
		return c;
	endfunction

	// A joint whose guess is mostly close to its position, so that most costs
	// stay below the clamp.
	function automatic item_t random_joint(input bit last);
		item_t j;
		j.position = pick_angle();
		if ($urandom_range(0, 3) == 0) begin
			j.initial_guess = pick_angle();
		end else begin
			j.initial_guess = j.position + 16'($urandom_range(0, 600) - 300);
		end
		j.limit_low = pick_angle();
		case ($urandom_range(0, 4))
			0:       j.limit_high = pick_angle();
			1:       j.limit_high = j.limit_low - 16'($urandom_range(0, 4096));
			default: j.limit_high = j.limit_low + 16'($urandom_range(0, 16384));
		endcase
		j.unbounded = ($urandom_range(0, 3) == 0);
		case ($urandom_range(0, 5))
			0:       j.velocity_limit = 16'h0000;
			1:       j.velocity_limit = 16'hFFFF;
			2:       j.velocity_limit = 16'($urandom());
			default: j.velocity_limit = 16'($urandom_range(0, 2047));
		endcase
		case ($urandom_range(0, 5))
			0:       j.acceleration_limit = 24'h000000;
			1:       j.acceleration_limit = 24'hFFFFFF;
			2:       j.acceleration_limit = 24'($urandom());
			default: j.acceleration_limit = 24'($urandom_range(0, 1 << 18));
		endcase
		j.last_joint = last;
		return j;
	endfunction

	// Stimulus sequence.
	initial begin
		int random_done;
		int phase_no;
		int n;
		int len;
		int k;
		cfg_wr_en = 1'b0;
		cfg_index = REG_W_DISP;
		cfg_data  = '0;
		arst_n   <= 1'b0;
		reg_mirror = config_of(0, 0, 0, 0, 0, INV_DT_RESET, 32'd0, 0);
		run_cost    = '0;
		run_index   = '0;
		run_clamped = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: every weight is zero, so the cost is zero.
		queue_joint(make_joint(0, 0, 0, 0, 0, 0, 0, 0));
		queue_joint(make_joint(32767, -32768, -32768, 32767, 1, 65535, 16777215, 1));
		drain();

		// Moderate weights, window on joint 1 and velocity on joint 2.
		load_config(config_of(256, 512, 1024, 256, 1, 1600, 32'h1000_F000, 8'h21));
		queue_joint(make_joint(0, 0, -8192, 8192, 0, 65535, 16777215, 0));
		queue_joint(make_joint(32767, -32768, -8192, 8192, 0, 0, 0, 0));
		// Unbounded joint with reversed limits, which must be ignored.
		queue_joint(make_joint(-32768, 32767, 32767, -32768, 1, 0, 0, 0));
		// Reversed limits on a bounded joint widen the penalty.
		queue_joint(make_joint(0, 0, 4096, -4096, 0, 0, 0, 0));
		queue_joint(make_joint(100, 90, -100, 100, 0, 16'h1234, 24'h00ABCD, 1));
		queue_joint(make_joint(5000, -5000, -32768, 32767, 0, 65535, 16777215, 1));
		drain();

		// Every weight and the rate at maximum: velocity and acceleration each hit the
		// clamp on their own, then a quiet joint shows that the flag has been cleared.
		load_config(config_of(65535, 65535, 65535, 65535, 65535, 65535, 32'd0, 8'h00));
		queue_joint(make_joint(32767, -32768, 0, 0, 0, 0, 0, 1));
		queue_joint(make_joint(0, 0, 0, 0, 1, 0, 0, 1));
		drain();

		// Acceleration alone: two terms just under the clamp overflow the sum.
		load_config(config_of(0, 0, 0, 0, 256, 65535, 32'h0000_0000, 8'hFF));
		queue_joint(make_joint(27, 0, 0, 0, 1, 0, 0, 0));
		queue_joint(make_joint(27, 0, 0, 0, 1, 0, 0, 1));
		queue_joint(make_joint(27, 0, 0, 0, 1, 0, 0, 1));
		drain();

		// Zero rate removes the velocity and acceleration terms; the window is
		// reversed.
		load_config(config_of(256, 0, 256, 65535, 65535, 0, 32'hF000_1000, 8'h00));
		queue_joint(make_joint(-32768, 32767, 0, 0, 0, 0, 0, 0));
		queue_joint(make_joint(1000, 0, 0, 0, 0, 0, 0, 1));
		drain();

		// Back-pressure: the receiver holds off while single-joint evaluations
		// keep arriving, so the core fills up and stalls its input.
		load_config(random_config());
		calm = 1'b1;
		for (k = 0; k < 24; k++) begin
			queue_joint(random_joint(1'b1));
		end
		hold_request = 1'b1;
		drain();
		calm = 1'b0;

		// Random evaluations under random settings; the last phases run
		// without idling on either side.
		random_done = 0;
		phase_no = 0;
		while (random_done < RANDOM_ITEMS) begin
			if (random_done >= RANDOM_ITEMS - 100) begin
				calm = 1'b1;
			end
			load_config(random_config());
			n = 0;
			while (n < 50) begin
				if (phase_no == 0 && n == 0) begin
					// Longer than the joint counter, so it wraps.
					len = 18;
				end else if ($urandom_range(0, 5) == 0) begin
					len = $urandom_range(14, 20);
				end else begin
					len = $urandom_range(1, 8);
				end
				for (k = 0; k < len; k++) begin
					queue_joint(random_joint(k == len - 1));
				end
				n += len;
			end
			random_done += n;
			phase_no++;
			drain();
		end

		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
